[rtl/polyline_unit_resampler_assert.svh]
// ----------------------------------------------------------------------------
// polyline_unit_resampler_assert
// assertion macros, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef POLYLINE_UNIT_RESAMPLER_ASSERT_SVH
`define POLYLINE_UNIT_RESAMPLER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PUR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pur assertion failed");
// antecedent implies consequent in the next cycle
`define PUR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pur assertion failed");
`else
`define PUR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PUR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/pur_pkg.sv]
// ----------------------------------------------------------------------------
// pur_pkg
// shared widths, defaults and sequencer states of the polyline resampler
// ----------------------------------------------------------------------------
`default_nettype none

package pur_pkg;

  localparam int COORD_W       = 24;
  localparam int DELTA_W       = COORD_W + 1;
  localparam int RAD_W         = 2 * DELTA_W;
  localparam int ROOT_STEPS    = DELTA_W;
  localparam int SUB_W         = DELTA_W + 3;
  localparam int MAX_PTS_DEF   = 62;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_ROUND,
    ST_PLAN,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_EMIT,
    ST_CLOSE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/pur_if.sv]
// ----------------------------------------------------------------------------
// pur_vtx_if / pur_pt_if
// valid/ready channels for input vertices and resampled points
// ----------------------------------------------------------------------------
`default_nettype none

interface pur_vtx_if;
  logic                                valid;
  logic                                ready;
  logic signed [pur_pkg::COORD_W-1:0]  vx;
  logic signed [pur_pkg::COORD_W-1:0]  vy;
  logic                                final_vertex;

  modport source (output valid, output vx, output vy, output final_vertex, input ready);
  modport sink (input valid, input vx, input vy, input final_vertex, output ready);
endinterface

interface pur_pt_if;
  logic                                valid;
  logic                                ready;
  logic signed [pur_pkg::COORD_W-1:0]  px;
  logic signed [pur_pkg::COORD_W-1:0]  py;
  logic                                end_of_line;
  logic                                truncated;

  modport source (output valid, output px, output py, output end_of_line,
                  output truncated, input ready);
  modport sink (input valid, input px, input py, input end_of_line,
                input truncated, output ready);
endinterface

`default_nettype wire

[rtl/polyline_unit_resampler.sv]
// ----------------------------------------------------------------------------
// polyline_unit_resampler
// resamples a polyline to points spaced one unit of arc length apart
// ----------------------------------------------------------------------------
// usage
//   vtx : vertices (vx, vy, final_vertex), one transfer per vertex
//   pt  : resampled points (px, py, end_of_line, truncated)
//   the first vertex of a polyline is passed through; each later vertex
//   closes a segment whose length comes from a bit-serial square root and
//   whose points come from one multiply and a bit-serial divide per axis
//   one shared 25x25 multiplier and one 28-bit subtractor; sequence:
//     first vertex  : passed to the output register
//     later vertex  : set-up (accept, two squares, sum,
//                     25 root steps, round, plan)
//                     then per emitted point two 25-step divides
//                     then a closing point on a final vertex, then finish
//   vtx.ready is high only while the sequencer is idle
//   the result sits in an output register; a stalled receiver holds the
//   sequencer at the next point until the register frees
//   reset: sequencer idle, no polyline open, output register empty
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_unit_resampler_assert.svh"

module polyline_unit_resampler #(
  parameter int MAX_POINTS_PER_SEGMENT = pur_pkg::MAX_PTS_DEF,
  parameter int FRAC_BITS              = pur_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pur_vtx_if.sink   vtx,
  pur_pt_if.source  pt
);

  import pur_pkg::*;

  // distance along the segment in units, six integer and FRAC_BITS fraction bits
  localparam int DW  = FRAC_BITS + 6;
  localparam int CW  = $clog2(MAX_POINTS_PER_SEGMENT + 1);
  localparam int TW  = DELTA_W + 1;
  localparam int SCW = $clog2(ROOT_STEPS);

  state_t state, state_next;

  // polyline state
  logic                       in_line;
  logic signed [COORD_W-1:0]  prev_x, prev_y;
  logic [FRAC_BITS-1:0]       walked;

  // current vertex and segment
  logic signed [COORD_W-1:0]  cur_x, cur_y;
  logic                       fin;
  logic signed [DELTA_W-1:0]  dx, dy;
  logic [DELTA_W-1:0]         mag_x, mag_y;

  // shared datapath registers
  logic [RAD_W-1:0]           prod;
  logic [RAD_W-1:0]           rad;
  logic [DELTA_W:0]           rem;
  logic [DELTA_W-1:0]         root;
  logic [DELTA_W-1:0]         len;
  logic [DELTA_W-1:0]         dlow;
  logic [DELTA_W-1:0]         quo;
  logic [SCW-1:0]             step;
  logic                       axis;

  // segment plan
  logic [DW-1:0]              arc_pos;
  logic [CW-1:0]              emit, k;
  logic                       trunc, need_close;
  logic [FRAC_BITS-1:0]       walked_new;
  logic signed [COORD_W-1:0]  pnt_x, pnt_y;

  // output register
  logic                       out_valid;
  logic signed [COORD_W-1:0]  out_x, out_y;
  logic                       out_eol, out_trunc;
  logic                       slot_free;
  logic                       out_load;

  // shared multiplier and subtractor
  logic [DELTA_W-1:0]         mul_a, mul_b;
  logic [RAD_W-1:0]           mul_p;
  logic [SUB_W-1:0]           sub_a, sub_b;
  logic [SUB_W:0]             diff;
  logic                       sub_ge;

  logic [TW-1:0]              total;
  logic                       trunc_c;
  logic [CW-1:0]              emit_c;
  logic [RAD_W-1:0]           numer;
  logic [DELTA_W-1:0]         q_final;
  logic signed [COORD_W+1:0]  q_signed, pnt_sum;
  logic                       last_step;

  assign mag_x     = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign mag_y     = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
  assign slot_free = !out_valid || pt.ready;
  assign out_load  = slot_free &&
                     (state == ST_FIRST || state == ST_EMIT || state == ST_CLOSE);
  assign last_step = (step == SCW'(ROOT_STEPS - 1));

  assign vtx.ready      = (state == ST_IDLE);
  assign pt.valid       = out_valid;
  assign pt.px          = out_x;
  assign pt.py          = out_y;
  assign pt.end_of_line = out_eol;
  assign pt.truncated   = out_trunc;

  // operand selection for the shared units
  always_comb begin
    mul_a = mag_x;
    mul_b = mag_x;
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      ST_SQY: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      ST_MUL: begin
        mul_a = axis ? mag_y : mag_x;
        mul_b = DELTA_W'(arc_pos);
      end
      ST_ROOT: begin
        // trial subtract of 4*root + 1 from the shifted remainder
        sub_a = {rem, rad[RAD_W-1 -: 2]};
        sub_b = SUB_W'({root, 2'b01});
      end
      ST_ROUND: begin
        // borrow here means rem > root, so round up
        sub_a = SUB_W'(root);
        sub_b = SUB_W'(rem);
      end
      ST_DIV: begin
        sub_a = SUB_W'({rem[DELTA_W-1:0], dlow[DELTA_W-1]});
        sub_b = SUB_W'(len);
      end
      default: begin
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !diff[SUB_W];

  // segment plan from length and carried distance
  assign total   = TW'(len) + TW'(walked);
  assign trunc_c = (total >> FRAC_BITS) > TW'(MAX_POINTS_PER_SEGMENT);
  assign emit_c  = trunc_c ? CW'(MAX_POINTS_PER_SEGMENT) : total[FRAC_BITS +: CW];

  // rounded numerator, quotient and point on the active axis
  assign numer    = prod + RAD_W'(len >> 1);
  assign q_final  = {quo[DELTA_W-2:0], sub_ge};
  assign q_signed = (axis ? dy[DELTA_W-1] : dx[DELTA_W-1])
                    ? -$signed({1'b0, q_final}) : $signed({1'b0, q_final});
  assign pnt_sum  = (axis ? (COORD_W+2)'(prev_y) : (COORD_W+2)'(prev_x)) + q_signed;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (vtx.valid) state_next = in_line ? ST_SQX : ST_FIRST;
      ST_FIRST:  if (slot_free) state_next = ST_IDLE;
      ST_SQX:    state_next = ST_SQY;
      ST_SQY:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (last_step) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_PLAN;
      ST_PLAN: begin
        if (emit_c == '0) state_next = fin ? ST_CLOSE : ST_FINISH;
        else              state_next = ST_MUL;
      end
      ST_MUL:    state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIV;
      ST_DIV:    if (last_step) state_next = axis ? ST_EMIT : ST_MUL;
      ST_EMIT: begin
        if (slot_free) begin
          if (k != emit)              state_next = ST_MUL;
          else if (fin && need_close) state_next = ST_CLOSE;
          else                        state_next = ST_FINISH;
        end
      end
      ST_CLOSE:  if (slot_free) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_line   <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      walked    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)      out_valid <= 1'b1;
      else if (pt.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (vtx.valid) begin
            cur_x <= vtx.vx;
            cur_y <= vtx.vy;
            fin   <= vtx.final_vertex;
            dx    <= DELTA_W'(vtx.vx) - DELTA_W'(prev_x);
            dy    <= DELTA_W'(vtx.vy) - DELTA_W'(prev_y);
          end
        end
        ST_FIRST: begin
          if (slot_free) begin
            out_x     <= cur_x;
            out_y     <= cur_y;
            out_eol   <= fin;
            out_trunc <= 1'b0;
            in_line   <= !fin;
            prev_x    <= fin ? '0 : cur_x;
            prev_y    <= fin ? '0 : cur_y;
            walked    <= '0;
          end
        end
        ST_SQX: prod <= mul_p;
        ST_SQY: begin
          rad  <= prod;
          prod <= mul_p;
        end
        ST_SUM: begin
          rad  <= rad + prod;
          rem  <= '0;
          root <= '0;
          step <= '0;
        end
        ST_ROOT: begin
          // one result bit per cycle
          rad  <= rad << 2;
          step <= step + SCW'(1);
          if (sub_ge) begin
            rem  <= diff[DELTA_W:0];
            root <= {root[DELTA_W-2:0], 1'b1};
          end else begin
            rem  <= sub_a[DELTA_W:0];
            root <= {root[DELTA_W-2:0], 1'b0};
          end
        end
        ST_ROUND: len <= sub_ge ? root : root + DELTA_W'(1);
        ST_PLAN: begin
          trunc      <= trunc_c;
          emit       <= emit_c;
          walked_new <= total[FRAC_BITS-1:0];
          need_close <= trunc_c || (total[FRAC_BITS-1:0] != '0) ||
                        ((total >> FRAC_BITS) == '0);
          arc_pos    <= (DW'(1) << FRAC_BITS) - DW'(walked);
          k          <= CW'(1);
          axis       <= 1'b0;
        end
        ST_MUL: prod <= mul_p;
        ST_LOAD: begin
          // quotient fits the delta width, so the top half is already below len
          rem  <= (DELTA_W+1)'(numer[RAD_W-1:DELTA_W]);
          dlow <= numer[DELTA_W-1:0];
          quo  <= '0;
          step <= '0;
        end
        ST_DIV: begin
          dlow <= dlow << 1;
          quo  <= q_final;
          step <= step + SCW'(1);
          rem  <= sub_ge ? diff[DELTA_W:0] : sub_a[DELTA_W:0];
          if (last_step) begin
            if (!axis) pnt_x <= pnt_sum[COORD_W-1:0];
            else       pnt_y <= pnt_sum[COORD_W-1:0];
            axis <= !axis;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_x     <= pnt_x;
            out_y     <= pnt_y;
            out_eol   <= fin && !need_close && (k == emit);
            out_trunc <= trunc;
            k         <= k + CW'(1);
            arc_pos   <= arc_pos + (DW'(1) << FRAC_BITS);
          end
        end
        ST_CLOSE: begin
          if (slot_free) begin
            out_x     <= cur_x;
            out_y     <= cur_y;
            out_eol   <= 1'b1;
            out_trunc <= trunc;
          end
        end
        ST_FINISH: begin
          in_line <= !fin;
          prev_x  <= fin ? '0 : cur_x;
          prev_y  <= fin ? '0 : cur_y;
          walked  <= fin ? '0 : walked_new;
        end
        default: begin
        end
      endcase
    end
  end

  // the divider never sees a zero-length segment
  `PUR_ASSERT_NOW(a_div_len_nonzero, clk, rst, state == ST_DIV, len != '0)
  // the point counter stays within the plan while emitting
  `PUR_ASSERT_NOW(a_emit_in_plan, clk, rst, state == ST_EMIT, (k != '0) && (k <= emit))
  // a finished final vertex closes the polyline
  `PUR_ASSERT_NEXT(a_final_closes, clk, rst, (state == ST_FINISH) && fin, !in_line)
  // a loaded closing point shows on pt as valid and end of line
  `PUR_ASSERT_NEXT(a_load_shows, clk, rst, (state == ST_CLOSE) && slot_free,
                   pt.valid && pt.end_of_line)

endmodule

`default_nettype wire
